// ===== src/lwtc_pkg.sv =====
// Package for the fully associative LRU write-through cache.
// Holds the sizes, command codes, transaction structs and the way-field helper.
// No dependencies; every other file imports it.
package lwtc_pkg;

    // Cache geometry and memory size.
    localparam int WAYS         = 8;
    localparam int MEMORY_WORDS = 1024;
    localparam int WAY_W        = $clog2(WAYS);
    localparam int TAG_W        = $clog2(MEMORY_WORDS);

    // Command codes.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_SNOOP = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    // One access request.
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [15:0] fill_data;
    } t_req;

    // One access result.
    typedef struct packed {
        logic [15:0] read_data;
        logic        hit;
        logic [2:0]  way;
        logic        memory_write;
        logic        address_error;
    } t_rsp;

    // Contents of one way as seen by the compare unit.
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [WAY_W-1:0] rec;
    } t_way_view;

    // Update command from the sequencer to the way store.
    typedef struct packed {
        logic             en;
        logic [WAY_W-1:0] way;
        logic             fill;
        logic [TAG_W-1:0] tag;
        logic             inval;
        logic             touch;
        logic             wr_word;
        logic [15:0]      word;
    } t_upd;

    // Outcome of a full scan over the ways.
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             inv_found;
        logic [WAY_W-1:0] inv_way;
        logic [WAY_W-1:0] lru_way;
    } t_scan;

    // Fit a way index into the 3-bit result field.
    function automatic logic [2:0] to_way_field(input logic [WAY_W-1:0] w);
        logic [31:0] wide;
        wide = 32'(w);
        return wide[2:0];
    endfunction

endpackage

// ===== src/lwtc_store.sv =====
// Way storage of the cache: valid bits, tags, data words and LRU ranks.
// Depends on lwtc_pkg for sizes and the view and update structs.
module lwtc_store import lwtc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WAY_W-1:0] i_rd_way,
    output t_way_view        o_view,
    output logic [15:0]      o_word,
    input  t_upd             i_upd
);

    logic             r_valid [WAYS];
    logic [TAG_W-1:0] r_tag   [WAYS];
    logic [15:0]      r_word  [WAYS];
    logic [WAY_W-1:0] r_rec   [WAYS];

    // Scan read port and the data word of the way being updated.
    assign o_view.valid = r_valid[i_rd_way];
    assign o_view.tag   = r_tag[i_rd_way];
    assign o_view.rec   = r_rec[i_rd_way];
    assign o_word       = r_word[i_upd.way];

    // Valid bits, tags and recency ranks. A touched way becomes the most
    // recent and every way that was more recent moves down one rank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WAYS; i++) begin
                r_valid[i] <= 1'b0;
                r_tag[i]   <= '0;
                r_rec[i]   <= WAY_W'(i);
            end
        end else if (i_upd.en) begin
            if (i_upd.fill) begin
                r_valid[i_upd.way] <= 1'b1;
                r_tag[i_upd.way]   <= i_upd.tag;
            end
            if (i_upd.inval) begin
                r_valid[i_upd.way] <= 1'b0;
            end
            if (i_upd.touch) begin
                for (int i = 0; i < WAYS; i++) begin
                    if (WAY_W'(i) == i_upd.way) begin
                        r_rec[i] <= WAY_W'(WAYS - 1);
                    end else if (r_rec[i] > r_rec[i_upd.way]) begin
                        r_rec[i] <= r_rec[i] - 1'b1;
                    end
                end
            end
        end
    end

    // Data words carry no reset; a way is always written before it is valid.
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.wr_word) begin
            r_word[i_upd.way] <= i_upd.word;
        end
    end

endmodule

// ===== src/lwtc_scan.sv =====
// Shared tag compare unit: examines one way per cycle and keeps the first hit,
// the first invalid way and the least recent way. Depends on lwtc_pkg.
module lwtc_scan import lwtc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_en,
    input  logic [WAY_W-1:0] i_idx,
    input  logic [TAG_W-1:0] i_tag,
    input  t_way_view        i_view,
    output t_scan            o_res
);

    logic             r_hit;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_inv;
    logic [WAY_W-1:0] r_inv_way;
    logic [WAY_W-1:0] r_lru_way;
    logic             match;

    assign match = i_view.valid && (i_view.tag == i_tag);

    // Tracking registers, cleared at the start of every transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hit     <= 1'b0;
            r_inv     <= 1'b0;
            r_hit_way <= '0;
            r_inv_way <= '0;
            r_lru_way <= '0;
        end else if (i_en) begin
            if (match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= i_idx;
            end
            if (!i_view.valid && !r_inv) begin
                r_inv     <= 1'b1;
                r_inv_way <= i_idx;
            end
            // Ranks form a permutation, so exactly one way holds rank zero.
            if (i_view.rec == '0) begin
                r_lru_way <= i_idx;
            end
        end
    end

    assign o_res.hit       = r_hit;
    assign o_res.hit_way   = r_hit_way;
    assign o_res.inv_found = r_inv;
    assign o_res.inv_way   = r_inv_way;
    assign o_res.lru_way   = r_lru_way;

endmodule

// ===== src/lru_write_through_cache.sv =====
// Channel   | Ports                  | Handshake
// ----------+------------------------+-------------------------------------------
// access in | i_req (t_req)          | accepted when start is high and busy is low
// result    | o_rsp (t_rsp)          | valid for one cycle while o_done is high
//
// A read, write or snoop scans the ways with one shared compare unit, one way
// per cycle, then updates the store in the finish state; o_done is registered
// from that state. A reserved command or an out-of-range address skips the scan
// and goes straight to the finish state. busy is high
// from the accepting edge until the result is shown; a new transaction may be
// accepted in the cycle its predecessor's result is shown. Reset is synchronous
// and active low and empties the cache. The receiver cannot stall results.
// Depends on lwtc_pkg, lwtc_store and lwtc_scan.
module lru_write_through_cache import lwtc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [WAY_W-1:0] r_idx, n_idx;
    t_req             r_req;
    logic             r_aerr;
    logic             r_done;
    t_rsp             r_rsp, n_rsp;

    logic             accept;
    logic             bad_addr;
    logic [TAG_W-1:0] tag;
    logic             act;
    logic             snoop;
    logic [WAY_W-1:0] sel_way;
    t_way_view        view;
    logic [15:0]      cur_word;
    t_scan            scan;
    t_upd             upd;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign bad_addr = {1'b0, i_req.address} >= 17'(MEMORY_WORDS);
    assign tag      = r_req.address[TAG_W-1:0];
    assign act      = !r_aerr && (r_req.command == CMD_READ || r_req.command == CMD_WRITE);
    assign snoop    = !r_aerr && (r_req.command == CMD_SNOOP);

    lwtc_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_way (r_idx),
        .o_view   (view),
        .o_word   (cur_word),
        .i_upd    (upd)
    );

    lwtc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept),
        .i_en    (r_state == ST_SCAN),
        .i_idx   (r_idx),
        .i_tag   (tag),
        .i_view  (view),
        .o_res   (scan)
    );

    // Way chosen for a read or write: the hit, else the first free, else LRU.
    always_comb begin
        priority if (scan.hit) begin
            sel_way = scan.hit_way;
        end else if (scan.inv_found) begin
            sel_way = scan.inv_way;
        end else begin
            sel_way = scan.lru_way;
        end
    end

    // Store update issued in the finishing cycle.
    always_comb begin
        upd.en      = (r_state == ST_FINISH);
        upd.way     = snoop ? scan.hit_way : sel_way;
        upd.fill    = act && !scan.hit;
        upd.tag     = tag;
        upd.inval   = snoop && scan.hit;
        upd.touch   = act;
        upd.wr_word = act && (r_req.command == CMD_WRITE || !scan.hit);
        upd.word    = (r_req.command == CMD_WRITE) ? r_req.write_data : r_req.fill_data;
    end

    // Result fields of the finishing transaction.
    always_comb begin
        n_rsp.read_data = '0;
        if (act && r_req.command == CMD_READ) begin
            n_rsp.read_data = scan.hit ? cur_word : r_req.fill_data;
        end
        n_rsp.hit          = (act || snoop) && scan.hit;
        n_rsp.way          = '0;
        if (act) begin
            n_rsp.way = to_way_field(sel_way);
        end else if (snoop && scan.hit) begin
            n_rsp.way = to_way_field(scan.hit_way);
        end
        n_rsp.memory_write  = act && (r_req.command == CMD_WRITE);
        n_rsp.address_error = r_aerr;
    end

    // Sequencer: idle, scan over the ways, finish.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (i_req.command == CMD_RSVD || bad_addr) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx == WAY_W'(WAYS - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= (r_state == ST_FINISH);
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_aerr <= bad_addr && (i_req.command != CMD_RSVD);
        end
        if (r_state == ST_FINISH) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== tb/tb_lru_write_through_cache.sv =====
// Self-checking testbench for the 8-way fully associative LRU write-through cache.
// Directed and random accesses are checked against a cycle-free predictor of the cache.
// Depends on lwtc_pkg and the lru_write_through_cache RTL.
`timescale 1ns / 100ps

module tb_lru_write_through_cache import lwtc_pkg::*; ();

    localparam int STALL_LIMIT    = 500;
    localparam int RANDOM_PHASES  = 35;
    localparam int PHASE_ACCESSES = 50;
    localparam int POOL_MAX       = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_done;
    t_rsp o_rsp;

    // Predicted cache contents.
    logic             line_valid [WAYS];
    logic [TAG_W-1:0] line_tag   [WAYS];
    logic [15:0]      line_word  [WAYS];
    logic [WAY_W-1:0] line_rank  [WAYS];

    t_rsp        pending_results[$];
    t_rsp        want_rsp;
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          gaps_on     = 1'b1;
    logic [15:0] hot_addr [POOL_MAX];

    lru_write_through_cache DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Empty cache, way i holds recency rank i.
    function automatic void clear_cache_state();
        for (int i = 0; i < WAYS; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_word[i]  = '0;
            line_rank[i]  = WAY_W'(i);
        end
    endfunction

    // Work out the result of one access and update the predicted cache.
    function automatic t_rsp predict_access(input t_req req);
        t_rsp             rsp;
        int               hit_way;
        int               slot;
        logic [WAY_W-1:0] old_rank;
        rsp = '0;
        if (req.command == CMD_RSVD)
            return rsp;
        if (req.address >= MEMORY_WORDS) begin
            rsp.address_error = 1'b1;
            return rsp;
        end
        // The lowest matching valid way wins.
        hit_way = -1;
        for (int i = WAYS - 1; i >= 0; i--)
            if (line_valid[i] && line_tag[i] == req.address[TAG_W-1:0])
                hit_way = i;
        if (req.command == CMD_SNOOP) begin
            if (hit_way >= 0) begin
                line_valid[hit_way] = 1'b0;
                rsp.hit = 1'b1;
                rsp.way = 3'(hit_way);
            end
            return rsp;
        end
        if (hit_way >= 0) begin
            rsp.hit = 1'b1;
            slot = hit_way;
        end else begin
            // First invalid way, else the least recently used one.
            slot = -1;
            for (int i = WAYS - 1; i >= 0; i--)
                if (!line_valid[i])
                    slot = i;
            if (slot < 0)
                for (int i = 0; i < WAYS; i++)
                    if (line_rank[i] == '0)
                        slot = i;
            line_valid[slot] = 1'b1;
            line_tag[slot]   = req.address[TAG_W-1:0];
            line_word[slot]  = req.fill_data;
        end
        if (req.command == CMD_WRITE) begin
            line_word[slot]  = req.write_data;
            rsp.memory_write = 1'b1;
        end else begin
            rsp.read_data = line_word[slot];
        end
        // Move the way to the most recent rank.
        old_rank = line_rank[slot];
        for (int i = 0; i < WAYS; i++)
            if (line_rank[i] > old_rank)
                line_rank[i] = line_rank[i] - 1'b1;
        line_rank[slot] = WAY_W'(WAYS - 1);
        rsp.way = 3'(slot);
        return rsp;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic t_req make_access(input logic [1:0] cmd, input logic [15:0] addr,
                                         input logic [15:0] wdata, input logic [15:0] fdata);
        t_req req;
        req.command    = cmd;
        req.address    = addr;
        req.write_data = wdata;
        req.fill_data  = fdata;
        return req;
    endfunction

    // Check each result against the oldest prediction, then predict the accepted access.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    error_count++;
                end else begin
                    want_rsp = pending_results.pop_front();
                    compare_field("read_data", want_rsp.read_data, o_rsp.read_data);
                    compare_field("hit", want_rsp.hit, o_rsp.hit);
                    compare_field("way", want_rsp.way, o_rsp.way);
                    compare_field("memory_write", want_rsp.memory_write, o_rsp.memory_write);
                    compare_field("address_error", want_rsp.address_error,
                                  o_rsp.address_error);
                end
            end
            if (start && !busy)
                pending_results.push_back(predict_access(i_req));
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_lru_write_through_cache: done, errors");
            $finish;
        end
    end

    // Send one access, idling first for a random number of cycles with junk on the bus.
    task automatic send_access(input t_req req);
        int          gap;
        logic [63:0] junk;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            junk = {$urandom(), $urandom()};
            start <= 1'b0;
            i_req <= junk[$bits(t_req)-1:0];
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
    endtask

    // Fill all ways from empty, with extreme data, then force an LRU eviction.
    task automatic test_fill_and_evict();
        send_access(make_access(CMD_READ, 16'd0, 16'h0000, 16'hFFFF));
        send_access(make_access(CMD_WRITE, 16'(MEMORY_WORDS - 1), 16'hFFFF, 16'h0000));
        for (int a = 2; a < WAYS; a++)
            send_access(make_access(CMD_WRITE, 16'(a), 16'h0000, 16'hFFFF));
        send_access(make_access(CMD_READ, 16'd0, 16'h0000, 16'h0000));
        send_access(make_access(CMD_READ, 16'd100, 16'hFFFF, 16'h00FF));
    endtask

    // A write hit updates the word; a read hit returns it.
    task automatic test_write_hit();
        send_access(make_access(CMD_WRITE, 16'd0, 16'h1234, 16'hFFFF));
        send_access(make_access(CMD_READ, 16'd0, 16'hFFFF, 16'hFFFF));
    endtask

    // Snoop hit, snoop miss, then a refill into the way the snoop freed.
    task automatic test_snoop();
        send_access(make_access(CMD_SNOOP, 16'd0, 16'hFFFF, 16'hFFFF));
        send_access(make_access(CMD_SNOOP, 16'd0, 16'h0000, 16'h0000));
        send_access(make_access(CMD_READ, 16'd0, 16'h0000, 16'hA5A5));
    endtask

    // Addresses at or beyond the memory size leave the cache untouched.
    task automatic test_address_errors();
        send_access(make_access(CMD_READ, 16'(MEMORY_WORDS), 16'hFFFF, 16'hFFFF));
        send_access(make_access(CMD_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_access(make_access(CMD_SNOOP, 16'h8000, 16'h0000, 16'h0000));
    endtask

    // The reserved command is ignored whatever the address.
    task automatic test_reserved_command();
        send_access(make_access(CMD_RSVD, 16'd0, 16'hFFFF, 16'hFFFF));
        send_access(make_access(CMD_RSVD, 16'hFFFF, 16'h0000, 16'h0000));
    endtask

    // Phases of traffic over a small address pool so hits, evictions and snoops recur.
    task automatic test_random_traffic();
        int          pool_size;
        int          sel;
        logic [1:0]  cmd;
        logic [15:0] addr;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(4, POOL_MAX);
            for (int k = 0; k < POOL_MAX; k++)
                hot_addr[k] = 16'($urandom_range(0, MEMORY_WORDS - 1));
            for (int n = 0; n < PHASE_ACCESSES; n++) begin
                sel  = $urandom_range(0, 99);
                addr = hot_addr[$urandom_range(0, pool_size - 1)];
                cmd  = 2'($urandom_range(CMD_READ, CMD_SNOOP));
                if (sel < 40)
                    cmd = CMD_READ;
                else if (sel < 65)
                    cmd = CMD_WRITE;
                else if (sel < 77)
                    cmd = CMD_SNOOP;
                else if (sel < 85)
                    addr = 16'($urandom_range(0, MEMORY_WORDS - 1));
                else if (sel < 93)
                    addr = 16'($urandom_range(MEMORY_WORDS, 65535));
                else begin
                    cmd  = CMD_RSVD;
                    addr = 16'($urandom_range(0, 65535));
                end
                send_access(make_access(cmd, addr, 16'($urandom()), 16'($urandom())));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Main sequence.
    initial begin
        clear_cache_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_evict();
        test_write_hit();
        test_snoop();
        test_address_errors();
        test_reserved_command();
        test_random_traffic();

        // Drain the outstanding transactions, then let the block settle.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (WAYS + 4) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_lru_write_through_cache: done, clean");
        else
            $display("tb_lru_write_through_cache: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lwtc_pkg.sv
src/lwtc_store.sv
src/lwtc_scan.sv
src/lru_write_through_cache.sv
tb/tb_lru_write_through_cache.sv
